// ===== hw/rtl/jtpw_pkg.sv =====
// ----------------------------------------------------------------------------
// jtpw_pkg: shared types and constants for the TAP path walker
// TAP state codes, the forced-reset clock count, the walk bound and the step result type.
// ----------------------------------------------------------------------------
package jtpw_pkg;

  // TAP state codes (IEEE 1149.1), unknown is 16 and kept in a 5-bit register
  localparam logic [3:0] TAP_RESET      = 4'd0;
  localparam logic [3:0] TAP_IDLE       = 4'd1;
  localparam logic [3:0] TAP_SEL_DR     = 4'd2;
  localparam logic [3:0] TAP_CAPTURE_DR = 4'd3;
  localparam logic [3:0] TAP_SHIFT_DR   = 4'd4;
  localparam logic [3:0] TAP_EXIT1_DR   = 4'd5;
  localparam logic [3:0] TAP_PAUSE_DR   = 4'd6;
  localparam logic [3:0] TAP_EXIT2_DR   = 4'd7;
  localparam logic [3:0] TAP_UPDATE_DR  = 4'd8;
  localparam logic [3:0] TAP_SEL_IR     = 4'd9;
  localparam logic [3:0] TAP_CAPTURE_IR = 4'd10;
  localparam logic [3:0] TAP_SHIFT_IR   = 4'd11;
  localparam logic [3:0] TAP_EXIT1_IR   = 4'd12;
  localparam logic [3:0] TAP_PAUSE_IR   = 4'd13;
  localparam logic [3:0] TAP_EXIT2_IR   = 4'd14;
  localparam logic [3:0] TAP_UPDATE_IR  = 4'd15;
  localparam logic [4:0] TAP_UNKNOWN    = 5'd16;

  // TMS ones sent to force a controller of unknown state into reset
  localparam int unsigned FORCE_CLOCKS = 5;
  // most TMS bits sent on one walk, forced ones included
  localparam int unsigned MAX_RESULTS  = 12;
  localparam int unsigned WALK_CNT_W   = $clog2(MAX_RESULTS);

  // one step of the walk: TMS chosen and the state it leads to
  typedef struct packed {
    logic       tms;
    logic [3:0] nxt;
  } step_t;

endpackage

// ===== hw/rtl/jtag_tap_path_walker.sv =====
// ----------------------------------------------------------------------------
// jtag_tap_path_walker: TMS sequence generator for a TAP state move
// Tracks the TAP controller state and walks it to each requested state.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis_*) carries one target TAP state per transfer. The
//   master stream (m_axis_*) returns one transfer per TCK: the TMS bit, the
//   state reached after that clock, and tlast on the clock that reaches the
//   target. A target of 16 or above means Test-Logic-Reset; a target equal to
//   the tracked state produces no transfer. The first result is loaded into
//   the output register from FORCE_RESET or WALK_PATH after the target is
//   accepted; the walk then loads one result per cycle unless m_axis_tready
//   stalls it. A walk sends up to 7 TMS bits from a known state, up to 11
//   after an unknown state (5 forced ones first).
//   A walk toward an Exit2 state from outside its Pause state never arrives
//   and is cut at 12 bits. s_axis_tready stays low while a walk runs and
//   rises again once the last result is loaded into the output register.
//   Reset: the tracked state becomes unknown, so the next walk starts with the
//   five forced TMS ones. A stall on m_axis_tready holds the output register
//   and freezes the walk, which lengthens the item.
// ----------------------------------------------------------------------------
module jtag_tap_path_walker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [4:0] target_state, [7:5] zero
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] tms_bit, [4:1] reached_state, [7:5] zero
  output logic       m_axis_tlast    // last_bit
);

  typedef enum logic [1:0] {
    WAIT_ITEM,
    FORCE_RESET,
    WALK_PATH
  } fsm_t;

  fsm_t                               fsm;
  logic [4:0]                         cur;      // tracked TAP state, 16 = unknown
  logic [3:0]                         tgt;
  logic [jtpw_pkg::WALK_CNT_W-1:0]    walk_cnt; // clocks sent for this walk

  logic       out_valid;
  logic       out_tms;
  logic [3:0] out_state;
  logic       out_last;

  logic            in_xfer;
  logic            load;
  logic [3:0]      in_tgt;
  jtpw_pkg::step_t step;

  // Map unknown targets to reset
  assign in_tgt  = s_axis_tdata[4] ? jtpw_pkg::TAP_RESET : s_axis_tdata[3:0];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  // Advance the walk only when the output register is free or being drained
  assign load    = !out_valid || m_axis_tready;

  jtpw_step u_step (
    .cur  (cur[3:0]),
    .tgt  (tgt),
    .step (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= WAIT_ITEM;
      cur       <= jtpw_pkg::TAP_UNKNOWN;
      walk_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      case (fsm)
        WAIT_ITEM: begin
          // Drain the last result of the previous walk
          if (out_valid && m_axis_tready) begin
            out_valid <= 1'b0;
          end
          if (in_xfer) begin
            tgt      <= in_tgt;
            walk_cnt <= '0;
            // Drop targets that are already reached
            if (cur != {1'b0, in_tgt}) begin
              if (cur[4]) begin
                fsm <= FORCE_RESET;
              end else begin
                fsm <= WALK_PATH;
              end
            end
          end
        end
        FORCE_RESET: begin
          if (load) begin
            out_valid <= 1'b1;
            out_tms   <= 1'b1;
            out_state <= jtpw_pkg::TAP_RESET;
            out_last  <= 1'b0;
            walk_cnt  <= walk_cnt + 1'b1;
            if (walk_cnt == jtpw_pkg::WALK_CNT_W'(jtpw_pkg::FORCE_CLOCKS - 1)) begin
              cur <= {1'b0, jtpw_pkg::TAP_RESET};
              if (tgt == jtpw_pkg::TAP_RESET) begin
                out_last <= 1'b1;
                fsm      <= WAIT_ITEM;
              end else begin
                fsm <= WALK_PATH;
              end
            end
          end
        end
        WALK_PATH: begin
          if (load) begin
            out_valid <= 1'b1;
            out_tms   <= step.tms;
            out_state <= step.nxt;
            out_last  <= (step.nxt == tgt);
            cur       <= {1'b0, step.nxt};
            walk_cnt  <= walk_cnt + 1'b1;
            // Stop on arrival, or at the clock bound for a target never reached
            if ((step.nxt == tgt) ||
                (walk_cnt == jtpw_pkg::WALK_CNT_W'(jtpw_pkg::MAX_RESULTS - 1))) begin
              fsm <= WAIT_ITEM;
            end
          end
        end
        default: begin
          fsm <= WAIT_ITEM;
        end
      endcase
    end
  end

  assign s_axis_tready = (fsm == WAIT_ITEM);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_state, out_tms};
  assign m_axis_tlast  = out_last;

endmodule

// ===== hw/rtl/jtpw_step.sv =====
// ----------------------------------------------------------------------------
// jtpw_step: one TAP path step
// Picks the TMS bit for a known state heading to a target and gives the
// state the TAP controller enters on that clock.
// ----------------------------------------------------------------------------
module jtpw_step (
  input  logic [3:0]     cur,
  input  logic [3:0]     tgt,
  output jtpw_pkg::step_t step
);

  logic tms;
  logic tgt_dr;
  logic tgt_ir;

  always_comb begin
    tgt_dr = tgt inside {[jtpw_pkg::TAP_SEL_DR : jtpw_pkg::TAP_UPDATE_DR]};
    tgt_ir = tgt inside {[jtpw_pkg::TAP_SEL_IR : jtpw_pkg::TAP_UPDATE_IR]};
  end

  // SVF path rules
  always_comb begin
    case (cur)
      jtpw_pkg::TAP_RESET: begin
        tms = 1'b0;
      end
      jtpw_pkg::TAP_SEL_DR: begin
        tms = (tgt == jtpw_pkg::TAP_RESET) || (tgt == jtpw_pkg::TAP_IDLE) || tgt_ir;
      end
      jtpw_pkg::TAP_SEL_IR: begin
        tms = (tgt == jtpw_pkg::TAP_RESET) || (tgt == jtpw_pkg::TAP_IDLE) || tgt_dr;
      end
      jtpw_pkg::TAP_CAPTURE_DR, jtpw_pkg::TAP_EXIT2_DR: begin
        tms = (tgt != jtpw_pkg::TAP_SHIFT_DR);
      end
      jtpw_pkg::TAP_CAPTURE_IR, jtpw_pkg::TAP_EXIT2_IR: begin
        tms = (tgt != jtpw_pkg::TAP_SHIFT_IR);
      end
      jtpw_pkg::TAP_EXIT1_DR: begin
        tms = (tgt != jtpw_pkg::TAP_PAUSE_DR);
      end
      jtpw_pkg::TAP_EXIT1_IR: begin
        tms = (tgt != jtpw_pkg::TAP_PAUSE_IR);
      end
      jtpw_pkg::TAP_UPDATE_DR, jtpw_pkg::TAP_UPDATE_IR: begin
        tms = (tgt != jtpw_pkg::TAP_IDLE);
      end
      default: begin
        tms = 1'b1;
      end
    endcase
  end

  // TAP controller transition table
  always_comb begin
    step.tms = tms;
    case (cur)
      jtpw_pkg::TAP_RESET:      step.nxt = tms ? jtpw_pkg::TAP_RESET    : jtpw_pkg::TAP_IDLE;
      jtpw_pkg::TAP_IDLE:       step.nxt = tms ? jtpw_pkg::TAP_SEL_DR   : jtpw_pkg::TAP_IDLE;
      jtpw_pkg::TAP_SEL_DR:     step.nxt = tms ? jtpw_pkg::TAP_SEL_IR   : jtpw_pkg::TAP_CAPTURE_DR;
      jtpw_pkg::TAP_CAPTURE_DR: step.nxt = tms ? jtpw_pkg::TAP_EXIT1_DR : jtpw_pkg::TAP_SHIFT_DR;
      jtpw_pkg::TAP_SHIFT_DR:   step.nxt = tms ? jtpw_pkg::TAP_EXIT1_DR : jtpw_pkg::TAP_SHIFT_DR;
      jtpw_pkg::TAP_EXIT1_DR:   step.nxt = tms ? jtpw_pkg::TAP_UPDATE_DR : jtpw_pkg::TAP_PAUSE_DR;
      jtpw_pkg::TAP_PAUSE_DR:   step.nxt = tms ? jtpw_pkg::TAP_EXIT2_DR : jtpw_pkg::TAP_PAUSE_DR;
      jtpw_pkg::TAP_EXIT2_DR:   step.nxt = tms ? jtpw_pkg::TAP_UPDATE_DR : jtpw_pkg::TAP_SHIFT_DR;
      jtpw_pkg::TAP_UPDATE_DR:  step.nxt = tms ? jtpw_pkg::TAP_SEL_DR   : jtpw_pkg::TAP_IDLE;
      jtpw_pkg::TAP_SEL_IR:     step.nxt = tms ? jtpw_pkg::TAP_RESET    : jtpw_pkg::TAP_CAPTURE_IR;
      jtpw_pkg::TAP_CAPTURE_IR: step.nxt = tms ? jtpw_pkg::TAP_EXIT1_IR : jtpw_pkg::TAP_SHIFT_IR;
      jtpw_pkg::TAP_SHIFT_IR:   step.nxt = tms ? jtpw_pkg::TAP_EXIT1_IR : jtpw_pkg::TAP_SHIFT_IR;
      jtpw_pkg::TAP_EXIT1_IR:   step.nxt = tms ? jtpw_pkg::TAP_UPDATE_IR : jtpw_pkg::TAP_PAUSE_IR;
      jtpw_pkg::TAP_PAUSE_IR:   step.nxt = tms ? jtpw_pkg::TAP_EXIT2_IR : jtpw_pkg::TAP_PAUSE_IR;
      jtpw_pkg::TAP_EXIT2_IR:   step.nxt = tms ? jtpw_pkg::TAP_UPDATE_IR : jtpw_pkg::TAP_SHIFT_IR;
      default:                  step.nxt = tms ? jtpw_pkg::TAP_SEL_DR   : jtpw_pkg::TAP_IDLE;
    endcase
  end

endmodule
